// ----- hw/rtl/slfqu_pkg.sv -----
// Shared types and constants of the sync/length frame quaternion unpacker.
package slfqu_pkg;

  localparam logic [7:0] SyncFirst    = 8'hAA;
  localparam logic [7:0] SyncSecond   = 8'h55;
  localparam int         QuatBytes    = 16;
  localparam logic [7:0] QuatFrameLen = 8'd17;
  localparam logic [7:0] QuatTypeRst  = 8'd1;

  typedef logic [7:0] byte_t;

  // Per-request commands from the frame parser to the cell row.
  typedef struct packed {
    logic shift;  // move the row one cell and load the new byte at the tail
    logic emit;   // this request completes a quaternion frame
  } slfqu_ctrl_t;

endpackage

// ----- hw/rtl/sync_length_frame_quat_unpacker.sv -----
// Top level of the sync/length frame parser that unpacks quaternion frames.
//
// The block takes one received serial byte per request and looks for frames of the form
// 0xAA, 0x55, length L, then L payload bytes, the first of which is the frame type.
// Bytes other than 0x55 that follow a 0xAA are skipped while the parser keeps waiting for
// 0x55, and a length of zero sends it straight back to the sync hunt. When a frame of
// length 17 ends and its type byte equals the quat_type_code register (reset value 1),
// one result request carries four signed Q30 components, w, x, y and z, built big-endian
// from payload bytes 1-4, 5-8, 9-12 and 13-16. All other frames are dropped silently.
// A new byte can be accepted every cycle while the input is not stalled; payload bytes
// 1 to 16 move through a row of sixteen byte cells, one cell per such byte, so the
// finished quaternion is read straight off the row as the last byte arrives. A result
// sits in an output register; the input stalls only while that register is full and the
// output is stalled. The type register may be written only while the block is idle.
module sync_length_frame_quat_unpacker
  import slfqu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  // Byte input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  // Quaternion result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] quat_w_o,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o
);

  byte_t       quat_type_code_q;
  logic        in_accept;
  slfqu_ctrl_t ctrl;
  byte_t       cell_in  [QuatBytes];
  byte_t       cell_out [QuatBytes];

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;

  // The configuration register is always ready to take a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_type_code_q <= QuatTypeRst;
    end else if (cfg_valid_i) begin
      quat_type_code_q <= cfg_data_i;
    end
  end

  // The output register frees up in the same cycle it is taken, so only a held result
  // that is stalled downstream blocks new bytes.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  slfqu_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .rx_byte_i        (rx_byte_i),
    .quat_type_code_i (quat_type_code_q),
    .ctrl_o           (ctrl)
  );

  // New bytes enter at the tail cell and walk toward cell 0, so after sixteen shifts
  // cell 0 holds payload byte 1.
  for (genvar i = 0; i < QuatBytes; i++) begin : g_cell
    if (i == QuatBytes - 1) begin : g_tail
      assign cell_in[i] = rx_byte_i;
    end else begin : g_body
      assign cell_in[i] = cell_out[i + 1];
    end

    slfqu_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl.shift),
      .data_i  (cell_in[i]),
      .data_o  (cell_out[i])
    );
  end

  // The row's next contents are exactly payload bytes 1 to 16 on the final byte, so the
  // result is taken from the cell inputs rather than from the cell outputs.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && ctrl.emit) begin
      quat_w_q <= {cell_in[0],  cell_in[1],  cell_in[2],  cell_in[3]};
      quat_x_q <= {cell_in[4],  cell_in[5],  cell_in[6],  cell_in[7]};
      quat_y_q <= {cell_in[8],  cell_in[9],  cell_in[10], cell_in[11]};
      quat_z_q <= {cell_in[12], cell_in[13], cell_in[14], cell_in[15]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign quat_w_o    = quat_w_q;
  assign quat_x_o    = quat_x_q;
  assign quat_y_o    = quat_y_q;
  assign quat_z_o    = quat_z_q;

endmodule

// ----- hw/rtl/slfqu_cell.sv -----
// One byte cell of the payload shift row.
module slfqu_cell
  import slfqu_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t data_i,
  output byte_t data_o
);

  byte_t data_q;

  // Payload storage only; contents are meaningful once a full frame has passed.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/slfqu_ctrl.sv -----
// Frame parser: sync hunt, length capture, payload counting and type check.
module slfqu_ctrl
  import slfqu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  byte_t       rx_byte_i,
  input  byte_t       quat_type_code_i,
  output slfqu_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    PhHuntAa,
    PhNeed55,
    PhNeedLen,
    PhPayload
  } phase_e;

  phase_e phase_q, phase_d;
  byte_t  count_q, count_d;
  byte_t  length_q, length_d;
  byte_t  kind_q, kind_d;
  byte_t  count_inc;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    length_d    = length_q;
    kind_d      = kind_q;
    ctrl_o      = '0;
    if (accept_i) begin
      unique case (phase_q)
        PhHuntAa: begin
          if (rx_byte_i == SyncFirst) phase_d = PhNeed55;
        end
        PhNeed55: begin
          if (rx_byte_i == SyncSecond) phase_d = PhNeedLen;
        end
        PhNeedLen: begin
          length_d = rx_byte_i;
          count_d  = '0;
          phase_d  = (rx_byte_i == '0) ? PhHuntAa : PhPayload;
        end
        PhPayload: begin
          if (count_q == '0) begin
            kind_d = rx_byte_i;
          end
          // Only payload bytes 1 to 16 enter the row.
          ctrl_o.shift = (count_q != '0) && (count_q <= 8'(QuatBytes));
          count_d      = count_inc;
          if (count_inc == length_q) begin
            phase_d     = PhHuntAa;
            ctrl_o.emit = (kind_q == quat_type_code_i) && (length_q == QuatFrameLen);
          end
        end
        default: phase_d = PhHuntAa;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHuntAa;
      count_q  <= '0;
      length_q <= '0;
      kind_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      length_q <= length_d;
      kind_q   <= kind_d;
    end
  end

endmodule
